### rtl/mcpg_pkg.sv
package mcpg_pkg;

    localparam int unsigned DEF_PANEL_WIDTH  = 240;
    localparam int unsigned DEF_PANEL_HEIGHT = 240;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    localparam logic [2:0] START_LAST_IDX = 3'd3;
    localparam logic [2:0] STEP_LAST_IDX  = 3'd7;

    // one queued job: the four axis points of a start or the eight points of a step
    typedef struct packed {
        logic        is_start;
        logic [9:0]  center_x;
        logic [9:0]  center_y;
        logic [15:0] color;
        logic [7:0]  off_a;
        logic [7:0]  off_b;
        logic        last;
    } job_t;

endpackage

### rtl/mcpg_front.sv
module mcpg_front
    import mcpg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [9:0]  s_center_x,
    input  logic [9:0]  s_center_y,
    input  logic [7:0]  s_radius,
    input  logic [15:0] s_pixel_color,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_push_data
);

    logic [9:0]         cx_reg, cx_next;
    logic [9:0]         cy_reg, cy_next;
    logic [15:0]        color_reg, color_next;
    logic [7:0]         x_reg, x_next;
    logic [7:0]         y_reg, y_next;
    logic signed [11:0] d_reg, d_next;
    logic [9:0]         sx_reg, sx_next;
    logic signed [10:0] sy_reg, sy_next;
    logic               active_reg, active_next;

    logic               accept;
    logic signed [10:0] sy_inc;
    logic [9:0]         sx_inc;
    logic signed [11:0] d_mid;
    logic [7:0]         x_step;
    logic [7:0]         y_step;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        sy_inc = sy_reg + 11'sd2;
        sx_inc = sx_reg + 10'd2;
        x_step = x_reg + 8'd1;
        if (d_reg >= 12'sd0) begin
            y_step = y_reg - 8'd1;
            d_mid  = d_reg + {sy_inc[10], sy_inc};
        end else begin
            y_step = y_reg;
            d_mid  = d_reg;
        end
    end

    always_comb begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        color_next  = color_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        active_next = active_reg;
        q_push      = 1'b0;
        q_push_data = '0;
        if (accept) begin
            if (s_mode == MODE_START) begin
                cx_next     = s_center_x;
                cy_next     = s_center_y;
                color_next  = s_pixel_color;
                x_next      = '0;
                y_next      = s_radius;
                d_next      = 12'sd1 - $signed({4'b0000, s_radius});
                sx_next     = 10'd1;
                sy_next     = 11'sd0 - $signed({2'b00, s_radius, 1'b0});
                active_next = (s_radius != 8'd0);
                q_push      = 1'b1;
                q_push_data.is_start = 1'b1;
                q_push_data.center_x = s_center_x;
                q_push_data.center_y = s_center_y;
                q_push_data.color    = s_pixel_color;
                q_push_data.off_a    = s_radius;
                q_push_data.off_b    = '0;
                q_push_data.last     = (s_radius == 8'd0);
            end else if (active_reg) begin
                x_next      = x_step;
                y_next      = y_step;
                sx_next     = sx_inc;
                if (d_reg >= 12'sd0) begin
                    sy_next = sy_inc;
                end
                d_next      = d_mid + $signed({2'b00, sx_inc});
                active_next = (x_step < y_step);
                q_push      = 1'b1;
                q_push_data.is_start = 1'b0;
                q_push_data.center_x = cx_reg;
                q_push_data.center_y = cy_reg;
                q_push_data.color    = color_reg;
                q_push_data.off_a    = x_step;
                q_push_data.off_b    = y_step;
                q_push_data.last     = !(x_step < y_step);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            color_reg  <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            d_reg      <= '0;
            sx_reg     <= 10'd1;
            sy_reg     <= '0;
            active_reg <= 1'b0;
        end else begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            color_reg  <= color_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            d_reg      <= d_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            active_reg <= active_next;
        end
    end

endmodule

### rtl/mcpg_queue.sv
module mcpg_queue
    import mcpg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/mcpg_back.sv
module mcpg_back
    import mcpg_pkg::*;
#(
    parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  job_t               q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [11:0] m_point_x,
    output logic signed [11:0] m_point_y,
    output logic               m_on_panel,
    output logic [15:0]        m_point_color,
    output logic               m_last_point
);

    localparam logic signed [11:0] PANEL_W = 12'(PANEL_WIDTH);
    localparam logic signed [11:0] PANEL_H = 12'(PANEL_HEIGHT);

    logic [2:0]         idx_reg, idx_next;
    logic               valid_reg, valid_next;
    logic signed [11:0] px_reg;
    logic signed [11:0] py_reg;
    logic               on_reg;
    logic [15:0]        color_reg;
    logic               last_reg;

    logic               load;
    logic               final_idx;
    logic signed [8:0]  pos_a, neg_a, pos_b, neg_b;
    logic signed [8:0]  dx, dy;
    logic signed [11:0] px, py;
    logic               on;

    assign m_valid       = valid_reg;
    assign m_point_x     = px_reg;
    assign m_point_y     = py_reg;
    assign m_on_panel    = on_reg;
    assign m_point_color = color_reg;
    assign m_last_point  = last_reg;

    assign load      = !q_empty && (!valid_reg || m_ready);
    assign final_idx = q_head.is_start ? (idx_reg == START_LAST_IDX)
                                       : (idx_reg == STEP_LAST_IDX);
    assign q_pop     = load && final_idx;

    // mirror order: start (0,r) (0,-r) (r,0) (-r,0); step (+x,+y) (-x,+y) (+x,-y) (-x,-y)
    // (+y,+x) (-y,+x) (+y,-x) (-y,-x)
    always_comb begin
        pos_a = $signed({1'b0, q_head.off_a});
        neg_a = 9'sd0 - pos_a;
        pos_b = $signed({1'b0, q_head.off_b});
        neg_b = 9'sd0 - pos_b;
        dx = '0;
        dy = '0;
        if (q_head.is_start) begin
            case (idx_reg[1:0])
                2'd0: begin dx = '0;    dy = pos_a; end
                2'd1: begin dx = '0;    dy = neg_a; end
                2'd2: begin dx = pos_a; dy = '0;    end
                default: begin dx = neg_a; dy = '0; end
            endcase
        end else begin
            case (idx_reg)
                3'd0: begin dx = pos_a; dy = pos_b; end
                3'd1: begin dx = neg_a; dy = pos_b; end
                3'd2: begin dx = pos_a; dy = neg_b; end
                3'd3: begin dx = neg_a; dy = neg_b; end
                3'd4: begin dx = pos_b; dy = pos_a; end
                3'd5: begin dx = neg_b; dy = pos_a; end
                3'd6: begin dx = pos_b; dy = neg_a; end
                default: begin dx = neg_b; dy = neg_a; end
            endcase
        end
        px = $signed({2'b00, q_head.center_x}) + {{3{dx[8]}}, dx};
        py = $signed({2'b00, q_head.center_y}) + {{3{dy[8]}}, dy};
        on = (px >= 12'sd0) && (px < PANEL_W) && (py >= 12'sd0) && (py < PANEL_H);
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = final_idx ? '0 : idx_reg + 3'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            px_reg    <= px;
            py_reg    <= py;
            on_reg    <= on;
            color_reg <= q_head.color;
            last_reg  <= q_head.last && final_idx;
        end
    end

endmodule

### rtl/midpoint_circle_pixel_generator.sv
// midpoint circle outline generator
// input channel (s_*): mode 0 starts a circle with center, radius and color,
// mode 1 advances the walk by one midpoint step
// result channel (m_*): one outline point per transaction, signed coordinates,
// on-panel flag, circle color and a flag on the last point of the circle
// a start gives 4 points, an active advance gives 8, an idle advance gives none
// the front takes one input transaction per cycle while the job queue has room
// and updates the walk state at once; the back emits one point per cycle
// while m_ready is high; jobs are registered in the job queue, points in the
// output register; the point emitter, which pops a job with its last point,
// sets the sustained rate; when m_ready is low the output register holds, the
// job queue (2 jobs) fills and then s_ready drops
// reset clears the walk, the queue and m_valid; no circle is in progress after it
module midpoint_circle_pixel_generator
    import mcpg_pkg::*;
#(
    parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [9:0]         s_center_x,
    input  logic [9:0]         s_center_y,
    input  logic [7:0]         s_radius,
    input  logic [15:0]        s_pixel_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [11:0] m_point_x,
    output logic signed [11:0] m_point_y,
    output logic               m_on_panel,
    output logic [15:0]        m_point_color,
    output logic               m_last_point
);

    logic q_full;
    logic q_push;
    job_t q_push_data;
    logic q_pop;
    logic q_empty;
    job_t q_head;

    mcpg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_radius      (s_radius),
        .s_pixel_color (s_pixel_color),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    mcpg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    mcpg_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_on_panel    (m_on_panel),
        .m_point_color (m_point_color),
        .m_last_point  (m_last_point)
    );

endmodule

### tb/midpoint_circle_pixel_generator_tb.sv
module midpoint_circle_pixel_generator_tb;
    import mcpg_pkg::*;

    localparam int PANEL_W      = DEF_PANEL_WIDTH;
    localparam int PANEL_H      = DEF_PANEL_HEIGHT;
    localparam int DIR_ROWS     = 22;
    localparam int RANDOM_ITEMS = 290;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic               on;
        logic [15:0]        color;
        logic               last;
    } point_t;

    typedef struct packed {
        logic        mode;
        logic [9:0]  cx;
        logic [9:0]  cy;
        logic [7:0]  radius;
        logic [15:0] color;
        logic        typed;
        logic [3:0]  typed_cnt;
        logic        typed_on;
    } stim_row_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE} rx_pattern_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_mode;
    logic [9:0]         s_center_x;
    logic [9:0]         s_center_y;
    logic [7:0]         s_radius;
    logic [15:0]        s_pixel_color;
    logic               m_valid;
    logic               m_ready;
    logic signed [11:0] m_point_x;
    logic signed [11:0] m_point_y;
    logic               m_on_panel;
    logic [15:0]        m_point_color;
    logic               m_last_point;

    midpoint_circle_pixel_generator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_radius      (s_radius),
        .s_pixel_color (s_pixel_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_on_panel    (m_on_panel),
        .m_point_color (m_point_color),
        .m_last_point  (m_last_point)
    );

    // circle walk state
    logic [9:0]         circ_cx;
    logic [9:0]         circ_cy;
    logic [15:0]        circ_color;
    logic [7:0]         walk_x;
    logic [7:0]         walk_y;
    logic signed [11:0] walk_d;
    logic [9:0]         walk_incx;
    logic signed [10:0] walk_incy;
    logic               walk_active;

    point_t    outline_points[$];
    stim_row_t dir_rows [DIR_ROWS];
    int        errors;
    int        cycle_count = 0;
    int        burst_left;
    bit        random_phase;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL midpoint_circle_pixel_generator");
            $finish;
        end
    end

    task automatic add_point(input int dx, input int dy, input bit last, input bit push_en);
        point_t p;
        int     px;
        int     py;
        px = int'(circ_cx) + dx;
        py = int'(circ_cy) + dy;
        p.x     = px[11:0];
        p.y     = py[11:0];
        p.on    = (px >= 0) && (px < PANEL_W) && (py >= 0) && (py < PANEL_H);
        p.color = circ_color;
        p.last  = last;
        if (push_en)
            outline_points.push_back(p);
    endtask

    task automatic circle_predict(input stim_row_t row, input bit push_en, output int n_points);
        int r;
        int x;
        int y;
        n_points = 0;
        if (row.mode == MODE_START) begin
            r = int'(row.radius);
            circ_cx     = row.cx;
            circ_cy     = row.cy;
            circ_color  = row.color;
            walk_x      = 8'd0;
            walk_y      = row.radius;
            walk_d      = 1 - r;
            walk_incx   = 10'd1;
            walk_incy   = -2 * r;
            walk_active = (r > 0);
            add_point(0, r, 1'b0, push_en);
            add_point(0, -r, 1'b0, push_en);
            add_point(r, 0, 1'b0, push_en);
            add_point(-r, 0, !walk_active, push_en);
            n_points = 4;
        end else if (walk_active) begin
            if (walk_d >= 0) begin
                walk_y    = walk_y - 8'd1;
                walk_incy = walk_incy + 11'sd2;
                walk_d    = walk_d + walk_incy;
            end
            walk_x    = walk_x + 8'd1;
            walk_incx = walk_incx + 10'd2;
            walk_d    = walk_d + signed'({2'b00, walk_incx});
            if (walk_x >= walk_y)
                walk_active = 1'b0;
            x = int'(walk_x);
            y = int'(walk_y);
            add_point(x, y, 1'b0, push_en);
            add_point(-x, y, 1'b0, push_en);
            add_point(x, -y, 1'b0, push_en);
            add_point(-x, -y, 1'b0, push_en);
            add_point(y, x, 1'b0, push_en);
            add_point(-y, x, 1'b0, push_en);
            add_point(y, -x, 1'b0, push_en);
            add_point(-y, -x, !walk_active, push_en);
            n_points = 8;
        end
    endtask

    // bursts of transactions with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_item(input stim_row_t row, input bit push_en, output int n_points);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_mode        <= row.mode;
        s_center_x    <= row.cx;
        s_center_y    <= row.cy;
        s_radius      <= row.radius;
        s_pixel_color <= row.color;
        do @(posedge aclk); while (!s_ready);
        circle_predict(row, push_en, n_points);
    endtask

    function automatic stim_row_t random_row(input logic mode);
        stim_row_t row;
        row        = '0;
        row.mode   = mode;
        row.cx     = $urandom_range(0, 1023);
        row.cy     = $urandom_range(0, 1023);
        row.color  = $urandom_range(0, 65535);
        row.radius = $urandom_range(0, 255);
        return row;
    endfunction

    initial begin : stimulus
        stim_row_t row;
        point_t    p;
        int        n;
        int        circle_items;
        int        k;
        int        sel;
        errors        = 0;
        burst_left    = 0;
        random_phase  = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_mode        = MODE_START;
        s_center_x    = '0;
        s_center_y    = '0;
        s_radius      = '0;
        s_pixel_color = '0;

        // mode, cx, cy, radius, color, typed, typed count, typed on-panel
        dir_rows = '{
            '{MODE_ADVANCE, 10'h3ff, 10'h3ff, 8'hff, 16'hffff, 1'b1, 4'd0, 1'b0},
            '{MODE_START,   10'd0,   10'd0,   8'd0,  16'h0000, 1'b1, 4'd4, 1'b1},
            '{MODE_ADVANCE, 10'd5,   10'd5,   8'd9,  16'h1111, 1'b1, 4'd0, 1'b0},
            '{MODE_START,   10'd1023, 10'd1023, 8'd0, 16'hffff, 1'b1, 4'd4, 1'b0},
            '{MODE_START,   10'd120, 10'd120, 8'd1,  16'h1234, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b1, 4'd0, 1'b0},
            '{MODE_START,   10'd0,   10'd0,   8'd255, 16'haaaa, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b0, 4'd0, 1'b0},
            '{MODE_START,   10'd1023, 10'd1023, 8'd255, 16'h5555, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b0, 4'd0, 1'b0},
            '{MODE_START,   10'd239, 10'd239, 8'd2,  16'h0f0f, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b1, 4'd0, 1'b0},
            '{MODE_START,   10'd1023, 10'd0,  8'd128, 16'h8000, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b0, 4'd0, 1'b0},
            '{MODE_START,   10'd0,   10'd1023, 8'd127, 16'h7fff, 1'b0, 4'd0, 1'b0},
            '{MODE_ADVANCE, 10'd0,   10'd0,   8'd0,  16'h0000, 1'b0, 4'd0, 1'b0}
        };

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            row = dir_rows[k];
            pace_sender();
            send_item(row, !row.typed, n);
            if (row.typed) begin
                for (int i = 0; i < row.typed_cnt; i++) begin
                    p.x     = {2'b00, row.cx};
                    p.y     = {2'b00, row.cy};
                    p.on    = row.typed_on;
                    p.color = row.color;
                    p.last  = (i == 3);
                    outline_points.push_back(p);
                end
            end
        end

        // let the block drain completely before the random part
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outline_points.size() != 0) @(posedge aclk);
        random_phase = 1'b1;

        circle_items = 0;
        while (circle_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 8) begin
                row = random_row($urandom_range(0, 1));
                pace_sender();
                send_item(row, 1'b1, n);
                if (n > 0)
                    circle_items++;
            end else begin
                row = random_row(MODE_START);
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    row.radius = $urandom_range(0, 20);
                else if (sel < 95)
                    row.radius = $urandom_range(21, 80);
                pace_sender();
                send_item(row, 1'b1, n);
                circle_items++;
                while (walk_active) begin
                    // occasionally restart before the circle is done
                    if ($urandom_range(0, 99) < 3)
                        break;
                    row = random_row(MODE_ADVANCE);
                    pace_sender();
                    send_item(row, 1'b1, n);
                    circle_items++;
                end
                if ($urandom_range(0, 99) < 15) begin
                    row = random_row(MODE_ADVANCE);
                    pace_sender();
                    send_item(row, 1'b1, n);
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (outline_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("PASS midpoint_circle_pixel_generator");
        else
            $display("FAIL midpoint_circle_pixel_generator");
        $finish;
    end

    initial begin : receiver
        rx_pattern_t pattern;
        int          span;
        int          phase;
        bit          held;
        m_ready = 1'b0;
        held    = 1'b0;
        phase   = 0;
        while (!aresetn) @(negedge aclk);
        forever begin
            if (random_phase && !held) begin
                // long hold so the job queue fills and backs up the input
                held = 1'b1;
                for (int i = 0; i < LONG_HOLD; i++) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end
            pattern = rx_pattern_t'($urandom_range(0, 2));
            span    = $urandom_range(10, 80);
            repeat (span) begin
                @(negedge aclk);
                phase++;
                case (pattern)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_COIN:   m_ready <= $urandom_range(0, 1);
                    default:   m_ready <= (phase % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : outline_check
        point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outline_points.size() == 0) begin
                $error("unexpected transaction: point_x %0d point_y %0d", m_point_x, m_point_y);
                errors++;
            end else begin
                want = outline_points.pop_front();
                if (m_point_x !== want.x) begin
                    $error("point_x: expected %0d, got %0d", want.x, m_point_x);
                    errors++;
                end
                if (m_point_y !== want.y) begin
                    $error("point_y: expected %0d, got %0d", want.y, m_point_y);
                    errors++;
                end
                if (m_on_panel !== want.on) begin
                    $error("on_panel: expected %0d, got %0d", want.on, m_on_panel);
                    errors++;
                end
                if (m_point_color !== want.color) begin
                    $error("point_color: expected %h, got %h", want.color, m_point_color);
                    errors++;
                end
                if (m_last_point !== want.last) begin
                    $error("last_point: expected %0d, got %0d", want.last, m_last_point);
                    errors++;
                end
            end
        end
    end

endmodule

### files.f
rtl/mcpg_pkg.sv
rtl/mcpg_front.sv
rtl/mcpg_queue.sv
rtl/mcpg_back.sv
rtl/midpoint_circle_pixel_generator.sv
tb/midpoint_circle_pixel_generator_tb.sv
